### design/tdt_pkg.sv
// Shared types and constants of the timed address dedup table.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package tdt_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int ADDR_W = 48;
   localparam int TIME_W = 32;
   localparam int SLOT_W = 5;
   localparam logic [TIME_W-1:0] RELOG_RESET = 32'd300000;

   typedef enum logic [1:0] {
      ACT_SUPPRESSED = 2'd0,
      ACT_REFRESHED  = 2'd1,
      ACT_INSERTED   = 2'd2,
      ACT_EVICTED    = 2'd3
   } action_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_CHECK = 5'b00100,
      ST_PLACE = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic take_hit;
      logic place;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic hit;
      logic last;
   } status_type;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
      logic [IDX_W+SLOT_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, idx};
      return wide[SLOT_W-1:0];
   endfunction

endpackage

### design/tdt_ctrl.sv
// Sequencer of the dedup table: accept, scan, place, respond.
// Depends on tdt_pkg; drives commands to tdt_datapath.
`timescale 1ns / 1ps

module tdt_ctrl
   import tdt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.empty ? ST_PLACE : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.hit) begin
               cmd.take_hit = 1'b1;
               state_in = ST_RESP;
            end else if (status.last) begin
               cmd.step = 1'b1;
               state_in = ST_PLACE;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

### design/tdt_datapath.sv
// Table stores, scan index, oldest tracking and result registers.
// Depends on tdt_pkg; commanded by tdt_ctrl.
`timescale 1ns / 1ps

module tdt_datapath
   import tdt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [ADDR_W-1:0] req_device_address,
   input  logic [TIME_W-1:0] req_now_ms,
   input  logic              csr_write,
   input  logic [TIME_W-1:0] csr_relog_interval,
   output logic              rsp_suppressed,
   output logic [1:0]        rsp_action,
   output logic [SLOT_W-1:0] rsp_slot
);

   logic [ADDR_W-1:0] addr_mem [TABLE_ENTRIES];
   logic [TIME_W-1:0] time_mem [TABLE_ENTRIES];

   logic [ADDR_W-1:0] addr_ff, rd_addr_ff;
   logic [TIME_W-1:0] now_ff, rd_time_ff, min_time_ff, relog_ff;
   logic [IDX_W-1:0]  idx_ff, min_slot_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              suppressed_ff;
   action_type        action_ff;
   logic [SLOT_W-1:0] slot_ff;

   logic [TIME_W-1:0] age;
   logic              full, in_window, take_min;
   logic [IDX_W-1:0]  place_idx;
   logic              addr_we, time_we;
   logic [IDX_W-1:0]  time_widx;

   assign age       = now_ff - rd_time_ff;
   assign in_window = (age < relog_ff);
   assign full      = (count_ff == CNT_W'(TABLE_ENTRIES));
   assign take_min  = (idx_ff == '0) || (rd_time_ff < min_time_ff);
   assign place_idx = full ? min_slot_ff : IDX_W'(count_ff);

   assign status.empty = (count_ff == '0);
   assign status.hit   = (rd_addr_ff == addr_ff);
   assign status.last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   assign addr_we   = cmd.place;
   assign time_we   = cmd.place || (cmd.take_hit && !in_window);
   assign time_widx = cmd.place ? place_idx : idx_ff;

   always_ff @(posedge clock) begin
      if (addr_we) begin
         addr_mem[place_idx] <= addr_ff;
      end
      if (time_we) begin
         time_mem[time_widx] <= now_ff;
      end
      rd_addr_ff <= addr_mem[idx_ff];
      rd_time_ff <= time_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         relog_ff <= RELOG_RESET;
      end else begin
         if (csr_write) begin
            relog_ff <= csr_relog_interval;
         end
         if (cmd.place && !full) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff <= req_device_address;
         now_ff  <= req_now_ms;
         idx_ff  <= '0;
      end
      if (cmd.step) begin
         if (take_min) begin
            min_time_ff <= rd_time_ff;
            min_slot_ff <= idx_ff;
         end
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (cmd.take_hit) begin
         suppressed_ff <= in_window;
         action_ff     <= in_window ? ACT_SUPPRESSED : ACT_REFRESHED;
         slot_ff       <= slot_of(idx_ff);
      end
      if (cmd.place) begin
         suppressed_ff <= 1'b0;
         action_ff     <= full ? ACT_EVICTED : ACT_INSERTED;
         slot_ff       <= slot_of(place_idx);
      end
   end

   assign rsp_suppressed = suppressed_ff;
   assign rsp_action     = action_ff;
   assign rsp_slot       = slot_ff;

endmodule

### design/timed_address_dedup_table_unit.sv
// Operation: each slot in use is scanned in order, a read state then a check state per slot,
// set by the registered read port of the table memories. A hit answers at once; a miss, or
// an empty table, places the word in a free slot or over the oldest before answering.
// Flow: one word at a time; the next word is taken after the result is taken.
// Reset: synchronous; empties the table, sets relog_interval to 300000, no clearing pass.
`timescale 1ns / 1ps

module timed_address_dedup_table_unit
   import tdt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [ADDR_W-1:0] req_device_address,
   input  logic [TIME_W-1:0] req_now_ms,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_suppressed,
   output logic [1:0]        rsp_action,
   output logic [SLOT_W-1:0] rsp_slot,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [TIME_W-1:0] csr_relog_interval
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   tdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tdt_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_device_address (req_device_address),
      .req_now_ms         (req_now_ms),
      .csr_write          (csr_valid && csr_ready),
      .csr_relog_interval (csr_relog_interval),
      .rsp_suppressed     (rsp_suppressed),
      .rsp_action         (rsp_action),
      .rsp_slot           (rsp_slot)
   );

endmodule
